/* sv/mard_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mard_pkg
// Shared constants, types and helpers for the adjacent row difference unit.
// ----------------------------------------------------------------------------
package mard_pkg;

  localparam int VALUE_BITS  = 20;
  localparam int MAX_COLUMNS = 1024;
  localparam int IDX_BITS    = $clog2(MAX_COLUMNS);
  localparam int COL_BITS    = IDX_BITS + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH) + 1;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last_item;
  } item_t;

  typedef struct packed {
    logic                 full;
    logic [QCNT_BITS-1:0] count;
  } queue_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } back_state_t;

  // Clamp the programmed row length into the supported range.
  function automatic logic [COL_BITS-1:0] effective_length(input logic [COL_BITS-1:0] len);
    logic [COL_BITS-1:0] r;
    if (len < COL_BITS'(2)) begin
      r = COL_BITS'(2);
    end else if (len > COL_BITS'(MAX_COLUMNS)) begin
      r = COL_BITS'(MAX_COLUMNS);
    end else begin
      r = len;
    end
    return r;
  endfunction

endpackage

/* sv/mard_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mard_front
// Accepts input requests and queues them for the back end.
// ----------------------------------------------------------------------------
module mard_front
  import mard_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  item_t         in_item,
  output logic          q_valid,
  output item_t         q_item,
  input  logic          q_pop,
  output queue_status_t status
);

  item_t                    entries [QUEUE_DEPTH];
  logic [QCNT_BITS-1:0]     count;
  logic [QCNT_BITS-2:0]     rd_ptr;
  logic [QCNT_BITS-2:0]     wr_ptr;
  logic                     push;
  logic                     pop;

  assign in_stall = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = entries[rd_ptr];
  assign status.full  = in_stall;
  assign status.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_BITS'(push) - QCNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

endmodule

/* sv/mard_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mard_back
// Compares each value with the stored previous row and keeps the least gap.
// ----------------------------------------------------------------------------
module mard_back
  import mard_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [COL_BITS-1:0]   len,
  input  logic                  q_valid,
  input  item_t                 q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] min_cost
);

  logic [VALUE_BITS-1:0] mem [2*MAX_COLUMNS];

  back_state_t           state, state_next;
  logic [VALUE_BITS-1:0] cur_v;
  logic                  cur_last;
  logic [COL_BITS-1:0]   k, k_next;
  logic                  rd_valid, rd_valid_next;
  logic [VALUE_BITS-1:0] rdata;
  logic [VALUE_BITS-1:0] best, best_next;
  logic [COL_BITS-1:0]   col, col_next;
  logic                  have_prev, have_prev_next;
  logic [COL_BITS-1:0]   plen, plen_next;
  logic                  bank, bank_next;
  logic                  load_out;
  logic                  mem_we;
  logic [IDX_BITS:0]     raddr;
  logic [IDX_BITS:0]     waddr;
  logic [VALUE_BITS-1:0] diff;
  logic [COL_BITS-1:0]   col_inc;

  assign diff    = (rdata > cur_v) ? (rdata - cur_v) : (cur_v - rdata);
  assign col_inc = col + 1'b1;
  assign raddr   = {~bank, k[IDX_BITS-1:0]};
  assign waddr   = {bank, col[IDX_BITS-1:0]};

  always_comb begin
    state_next     = state;
    k_next         = k;
    rd_valid_next  = 1'b0;
    best_next      = best;
    col_next       = col;
    have_prev_next = have_prev;
    plen_next      = plen;
    bank_next      = bank;
    q_pop          = 1'b0;
    load_out       = 1'b0;
    mem_we         = 1'b0;

    if (rd_valid && (diff < best)) begin
      best_next = diff;
    end

    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          k_next = '0;
          state_next = (have_prev && (plen != '0)) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        rd_valid_next = 1'b1;
        k_next        = k + 1'b1;
        if (k_next == plen) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // hold a last request while the previous result is still waiting
        if (!(cur_last && out_valid && out_stall)) begin
          mem_we = 1'b1;
          if (col_inc >= len) begin
            bank_next      = ~bank;
            plen_next      = col_inc;
            have_prev_next = 1'b1;
            col_next       = '0;
          end else begin
            col_next = col_inc;
          end
          if (cur_last) begin
            load_out       = 1'b1;
            best_next      = '1;
            col_next       = '0;
            have_prev_next = 1'b0;
            plen_next      = '0;
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_valid  <= 1'b0;
      best      <= '1;
      col       <= '0;
      have_prev <= 1'b0;
      plen      <= '0;
      bank      <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      state     <= state_next;
      rd_valid  <= rd_valid_next;
      best      <= best_next;
      col       <= col_next;
      have_prev <= have_prev_next;
      plen      <= plen_next;
      bank      <= bank_next;
      k         <= k_next;
      out_valid <= (out_valid && out_stall) || load_out;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_v    <= q_item.value;
      cur_last <= q_item.last_item;
    end
    if (load_out) begin
      min_cost <= best;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= cur_v;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/min_adjacent_row_difference_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_adjacent_row_difference_unit
// Least absolute difference between values of neighbouring matrix rows.
// ----------------------------------------------------------------------------
// channel | handshake             | payload
// in      | in_valid / in_stall   | value[19:0], last_item
// out     | out_valid / out_stall | min_cost[19:0]
// cfg     | cfg_we                | cfg_data[10:0] (row length)
//
// In the back end each request makes one memory read per element of the
// stored previous row, and none in the first row. A four-deep queue takes
// requests while the back end scans.
// Reset clears control state synchronously; the row memory needs no clearing.
// A stalled result holds the back end only at the next last request.
// ----------------------------------------------------------------------------
module min_adjacent_row_difference_unit
  import mard_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [COL_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  last_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] min_cost
);

  logic [COL_BITS-1:0] row_length;
  item_t               in_item;
  item_t               q_item;
  logic                q_valid;
  logic                q_pop;
  queue_status_t       status;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= COL_BITS'(2);
    end else if (cfg_we) begin
      row_length <= cfg_data;
    end
  end

  assign in_item.value     = value;
  assign in_item.last_item = last_item;

  mard_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .status   (status)
  );

  mard_back u_back (
    .clk       (clk),
    .rst       (rst),
    .len       (effective_length(row_length)),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .min_cost  (min_cost)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    status.count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    status.full == in_stall)
    else $error("full flag and stall disagree");

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule
